### design/premultiplied_argb_to_png_row_packer_core_defines.svh
// assertion macros shared by the packer modules
`ifndef PREMULTIPLIED_ARGB_TO_PNG_ROW_PACKER_CORE_DEFINES_SVH
`define PREMULTIPLIED_ARGB_TO_PNG_ROW_PACKER_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define PRPK_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("prpk check failed: expression false");

// consequence that must hold in the cycle after the trigger
`define PRPK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prpk check failed: next-cycle consequence false");

`endif

### design/prpk_pkg.sv
package prpk_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_COLOR_TYPE   = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_DEPTH = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND   = 2'd2;

  localparam logic [2:0]  COLOR_TYPE_RESET = 3'd6;
  localparam logic [4:0]  DEPTH_RESET      = 5'd8;
  localparam logic [4:0]  DEPTH_1          = 5'd1;
  localparam logic [4:0]  DEPTH_2          = 5'd2;
  localparam logic [4:0]  DEPTH_4          = 5'd4;
  localparam logic [4:0]  DEPTH_16         = 5'd16;

  // luminance weights and the divide by 5000 done as reciprocal multiply
  localparam logic [11:0] LUMA_R     = 12'd1063;
  localparam logic [11:0] LUMA_G     = 12'd3576;
  localparam logic [11:0] LUMA_B     = 12'd361;
  localparam logic [11:0] LUMA_BIAS  = 12'd2500;
  localparam logic [12:0] LUMA_DIV   = 13'd5000;
  localparam logic [19:0] LUMA_RECIP = 20'd858993;  // floor(2^32 / 5000)

  typedef struct packed {
    logic [2:0]  colour_mode;
    logic [4:0]  sample_depth;
    logic [23:0] background_rgb;
  } cfg_t;

  // one classified pixel handed from the front to the back
  typedef struct packed {
    logic        pack;        // sub-byte gray packing
    logic [3:0]  sample_top;  // luminance bits 15:12
    logic [2:0]  pack_depth;  // 1, 2 or 4
    logic        end_of_row;
    logic [3:0]  byte_cnt;    // byte formats only
    logic [63:0] bytes;       // byte 0 in bits 7:0, sent first
  } cmd_t;

endpackage

### design/prpk_front.sv
module prpk_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_pixel_word,
  input  logic             in_end_of_row,
  input  prpk_pkg::cfg_t   cfg,
  output logic             push,
  output prpk_pkg::cmd_t   push_cmd,
  input  logic             q_full
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SUM, S_SCL, S_MUL, S_FIX, S_PUSH
  } state_t;

  state_t            state_r;
  logic [1:0]        step_r;
  logic [7:0]        alpha_r;
  logic              transp_r;
  logic              eor_r;
  logic              colour_r;
  logic              alpha_en_r;
  logic              wide_r;
  logic              pack_r;
  logic [2:0]        pdepth_r;
  logic [2:0][7:0]   chan_r;
  logic [2:0][7:0]   rem_r;
  logic [2:0][7:0]   lo_r;
  logic [2:0][7:0]   quo_r;
  logic [2:0][7:0]   rgb_r;
  logic [20:0]       sum_r;
  logic [28:0]       x_r;
  logic [48:0]       prod_r;
  logic [15:0]       y_r;

  logic [2:0][7:0]   rem_nxt;
  logic [2:0][7:0]   lo_nxt;
  logic [2:0][7:0]   quo_nxt;
  logic [2:0][8:0]   t1;
  logic [2:0][8:0]   d1;
  logic [2:0][8:0]   t2;
  logic [2:0][8:0]   d2;
  logic [2:0]        ge1;
  logic [2:0]        ge2;
  logic [2:0][7:0]   fin;
  logic [20:0]       sum_nxt;
  logic [16:0]       q0;
  logic [28:0]       qm;
  logic [28:0]       rem_lum;
  logic [16:0]       y_nxt;
  logic [7:0]        acc_a;
  logic [23:0]       acc_src;
  logic [2:0][7:0]   acc_chan;
  logic [2:0][15:0]  acc_num;
  logic [7:0][7:0]   bl;
  logic [3:0]        bcnt;
  logic [2:0]        abase;

  assign in_ready = (state_r == S_IDLE);
  assign push     = (state_r == S_PUSH) && !q_full;

  // accept-time split of the pixel and the restoring divide seed
  always_comb begin
    acc_a   = in_pixel_word[31:24];
    acc_src = (acc_a == 8'd0) ? cfg.background_rgb : in_pixel_word[23:0];
    for (int l = 0; l < 3; l++) begin
      acc_chan[l] = acc_src[23 - 8*l -: 8];
      acc_num[l]  = {acc_chan[l], 8'h00} - {8'h00, acc_chan[l]} + {9'd0, acc_a[7:1]};
    end
  end

  // two quotient bits per cycle in each lane
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t1[l]      = {rem_r[l], lo_r[l][7]};
      ge1[l]     = (t1[l] >= {1'b0, alpha_r});
      d1[l]      = ge1[l] ? (t1[l] - {1'b0, alpha_r}) : t1[l];
      t2[l]      = {d1[l][7:0], lo_r[l][6]};
      ge2[l]     = (t2[l] >= {1'b0, alpha_r});
      d2[l]      = ge2[l] ? (t2[l] - {1'b0, alpha_r}) : t2[l];
      rem_nxt[l] = d2[l][7:0];
      quo_nxt[l] = {quo_r[l][5:0], ge1[l], ge2[l]};
      lo_nxt[l]  = {lo_r[l][5:0], 2'b00};
      fin[l]     = transp_r ? chan_r[l] :
                   ((chan_r[l] >= alpha_r) ? 8'hff : quo_r[l]);
    end
  end

  always_comb begin
    sum_nxt = 21'(fin[0]) * 21'(prpk_pkg::LUMA_R)
            + 21'(fin[1]) * 21'(prpk_pkg::LUMA_G)
            + 21'(fin[2]) * 21'(prpk_pkg::LUMA_B);
    q0      = prod_r[48:32];
    qm      = 29'(q0) * 29'(prpk_pkg::LUMA_DIV);
    rem_lum = x_r - qm;
    y_nxt   = (rem_lum >= 29'(prpk_pkg::LUMA_DIV)) ? (q0 + 17'd1) : q0;
  end

  // byte list for the byte-wide formats
  always_comb begin
    bl    = '0;
    bcnt  = 4'd0;
    abase = 3'd0;
    unique case ({colour_r, wide_r})
      2'b11: begin
        bl[0] = rgb_r[0]; bl[1] = rgb_r[0];
        bl[2] = rgb_r[1]; bl[3] = rgb_r[1];
        bl[4] = rgb_r[2]; bl[5] = rgb_r[2];
        bcnt  = 4'd6;
      end
      2'b10: begin
        bl[0] = rgb_r[0]; bl[1] = rgb_r[1]; bl[2] = rgb_r[2];
        bcnt  = 4'd3;
      end
      2'b01: begin
        bl[0] = y_r[15:8]; bl[1] = y_r[7:0];
        bcnt  = 4'd2;
      end
      default: begin
        bl[0] = y_r[15:8];
        bcnt  = 4'd1;
      end
    endcase
    abase = bcnt[2:0];
    if (alpha_en_r) begin
      bl[abase] = alpha_r;
      if (wide_r) begin
        bl[abase + 3'd1] = alpha_r;
        bcnt = bcnt + 4'd2;
      end else begin
        bcnt = bcnt + 4'd1;
      end
    end
  end

  always_comb begin
    push_cmd.pack       = pack_r;
    push_cmd.sample_top = y_r[15:12];
    push_cmd.pack_depth = pdepth_r;
    push_cmd.end_of_row = eor_r;
    push_cmd.byte_cnt   = bcnt;
    push_cmd.bytes      = bl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 2'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_DIV;
            step_r     <= 2'd0;
            alpha_r    <= acc_a;
            transp_r   <= (acc_a == 8'd0);
            eor_r      <= in_end_of_row;
            colour_r   <= cfg.colour_mode[1];
            alpha_en_r <= cfg.colour_mode[2];
            wide_r     <= (cfg.sample_depth == prpk_pkg::DEPTH_16);
            pack_r     <= !cfg.colour_mode[1] && !cfg.colour_mode[2] &&
                          ((cfg.sample_depth == prpk_pkg::DEPTH_1) ||
                           (cfg.sample_depth == prpk_pkg::DEPTH_2) ||
                           (cfg.sample_depth == prpk_pkg::DEPTH_4));
            pdepth_r   <= cfg.sample_depth[2:0];
            for (int l = 0; l < 3; l++) begin
              chan_r[l] <= acc_chan[l];
              rem_r[l]  <= acc_num[l][15:8];
              lo_r[l]   <= acc_num[l][7:0];
              quo_r[l]  <= 8'd0;
            end
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          lo_r   <= lo_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          rgb_r   <= fin;
          sum_r   <= sum_nxt;
          state_r <= S_SCL;
        end
        S_SCL: begin
          x_r     <= {sum_r, 8'h00} + 29'(sum_r) + 29'(prpk_pkg::LUMA_BIAS);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 49'(x_r) * 49'(prpk_pkg::LUMA_RECIP);
          state_r <= S_FIX;
        end
        S_FIX: begin
          y_r     <= y_nxt[15:0];
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/prpk_fifo.sv
`include "premultiplied_argb_to_png_row_packer_core_defines.svh"

module prpk_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prpk_pkg::cmd_t   push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output prpk_pkg::cmd_t   pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  prpk_pkg::cmd_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `PRPK_ASSERT_ALWAYS(a_no_push_full, !(push && full))
  `PRPK_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !pop_valid))
  `PRPK_ASSERT_NEXT(a_pop_drains, pop && !push, count_r == $past(count_r) - CW'(1))

endmodule

### design/prpk_back.sv
`include "premultiplied_argb_to_png_row_packer_core_defines.svh"

module prpk_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  prpk_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_of_pixel
);

  logic [63:0] bytes_r;
  logic [3:0]  cnt_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [2:0]  off_r;
  logic [7:0]  part_r;

  logic        emit_now;
  logic        load_ok;
  logic [2:0]  d;
  logic [3:0]  sum4;
  logic        flush;
  logic [2:0]  offb;
  logic [7:0]  base;
  logic [7:0]  smp8;
  logic [2:0]  shamt;
  logic [7:0]  merged;
  logic [3:0]  offb2;
  logic        emit2;
  logic [63:0] load_bytes;
  logic [3:0]  load_cnt;
  logic [2:0]  off_nxt;
  logic [7:0]  part_nxt;

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_pixel = out_last_r;

  assign emit_now = (cnt_r != 4'd0) && (!out_valid_r || out_ready);
  assign load_ok  = (cnt_r == 4'd0) || ((cnt_r == 4'd1) && emit_now);
  assign q_pop    = q_valid && load_ok;

  // sub-byte packing of one gray sample, or the byte list of a byte format
  always_comb begin
    d      = q_cmd.pack_depth;
    sum4   = {1'b0, off_r} + {1'b0, d};
    flush  = (sum4 > 4'd8);
    offb   = flush ? 3'd0 : off_r;
    base   = flush ? 8'd0 : part_r;
    smp8   = {4'd0, q_cmd.sample_top} >> (3'd4 - d);
    shamt  = 3'(4'd8 - {1'b0, d} - {1'b0, offb});
    merged = base | (smp8 << shamt);
    offb2  = {1'b0, offb} + {1'b0, d};
    emit2  = (offb2 >= 4'd8) || (q_cmd.end_of_row && (offb2 != 4'd0));

    if (q_cmd.pack) begin
      if (flush) begin
        load_bytes = {48'd0, merged, part_r};
        load_cnt   = emit2 ? 4'd2 : 4'd1;
      end else begin
        load_bytes = {56'd0, merged};
        load_cnt   = emit2 ? 4'd1 : 4'd0;
      end
      off_nxt  = emit2 ? 3'd0 : offb2[2:0];
      part_nxt = emit2 ? 8'd0 : merged;
    end else begin
      load_bytes = q_cmd.bytes;
      load_cnt   = q_cmd.byte_cnt;
      off_nxt    = 3'd0;
      part_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
      off_r       <= 3'd0;
      part_r      <= 8'd0;
    end else begin
      if (emit_now) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= bytes_r[7:0];
        out_last_r  <= (cnt_r == 4'd1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (q_pop) begin
        bytes_r <= load_bytes;
        cnt_r   <= load_cnt;
        off_r   <= off_nxt;
        part_r  <= part_nxt;
      end else if (emit_now) begin
        bytes_r <= {8'd0, bytes_r[63:8]};
        cnt_r   <= cnt_r - 4'd1;
      end
    end
  end

  `PRPK_ASSERT_ALWAYS(a_part_low_clear, (part_r & (8'hff >> off_r)) == 8'd0)
  `PRPK_ASSERT_ALWAYS(a_cnt_range, cnt_r <= 4'd8)
  `PRPK_ASSERT_NEXT(a_last_tag, emit_now, out_valid_r && (out_last_r == ($past(cnt_r) == 4'd1)))

endmodule

### design/premultiplied_argb_to_png_row_packer_core.sv
// premultiplied argb32 pixel to png scanline byte packer
//
// input channel: in_valid/in_ready carries one pixel request (in_pixel_word,
// alpha in 31:24, and in_end_of_row). output channel: out_valid/out_ready
// carries one scanline byte per request, out_last_of_pixel marks the final
// byte a pixel causes. packed gray pixels may cause no byte at all.
// configuration: cfg_we with cfg_index 0 colour type, 1 sample depth,
// 2 background rgb; write only while the block is idle.
//
// the front takes one pixel at a time, in steps: an accept step, the
// three-lane restoring divider (two quotient bits per cycle), the
// luminance steps (weighted sum, scale, reciprocal multiply, correction)
// and a queue push; it takes no new pixel until the push is done. the
// back sends one byte per cycle while the receiver is ready.
// a stalled receiver holds the output register; the queue then fills and
// the front waits in its push step before it takes the next pixel.
// reset (synchronous, active low) empties the queue, clears the packing
// state and restores rgba, 8 bit, black background.
module premultiplied_argb_to_png_row_packer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel_word,
  input  logic        in_end_of_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // configuration registers
  prpk_pkg::cfg_t cfg_r;

  // front to queue
  logic           push;
  prpk_pkg::cmd_t push_cmd;
  logic           q_full;

  // queue to back
  logic           q_valid;
  prpk_pkg::cmd_t q_cmd;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colour_mode    <= prpk_pkg::COLOR_TYPE_RESET;
      cfg_r.sample_depth   <= prpk_pkg::DEPTH_RESET;
      cfg_r.background_rgb <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prpk_pkg::CFG_COLOR_TYPE: begin
          cfg_r.colour_mode <= cfg_data[2:0];
        end
        prpk_pkg::CFG_SAMPLE_DEPTH: begin
          cfg_r.sample_depth <= cfg_data[4:0];
        end
        prpk_pkg::CFG_BACKGROUND: begin
          cfg_r.background_rgb <= cfg_data;
        end
        default: begin
          // unused index, write ignored
        end
      endcase
    end
  end

  // front: accept, unpremultiply, luminance, classify
  prpk_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_word (in_pixel_word),
    .in_end_of_row (in_end_of_row),
    .cfg           (cfg_r),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  // short queue decoupling the two halves
  prpk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_cmd)
  );

  // back: sub-byte packing and byte serialisation
  prpk_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_pixel (out_last_of_pixel)
  );

endmodule
